// File: rtl/core/u8n1_pkg.sv
// Shared types and constants for the 8N1 serial transceiver.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package u8n1_pkg;

  // Frame geometry
  localparam int DATA_BITS   = 8;
  localparam int TX_LAST_INT = 2 * (DATA_BITS + 2);
  localparam int PHASE_W     = $clog2(TX_LAST_INT + 1);
  localparam int TIMER_W     = 16;
  localparam int BYTE_W      = 8;

  localparam logic [PHASE_W-1:0]   TX_LAST_PHASE = PHASE_W'(TX_LAST_INT);
  localparam logic [PHASE_W-2:0]   DATA_IDX      = (PHASE_W - 1)'(DATA_BITS);
  localparam logic [TIMER_W-1:0]   HALF_BIT_RST  = TIMER_W'(31);

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;

  // Item kind carried in tuser
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SEND = 1'b1
  } op_e_t;

  // Classified input item
  typedef struct packed {
    op_e_t             kind;
    logic [BYTE_W-1:0] send_byte;
    logic              rx_line;
  } item_t;

  // Result item; first member is the top bit, so tx_line lands in bit 0
  typedef struct packed {
    logic              rx_error;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_valid;
    logic              tx_done;
    logic              tx_busy;
    logic              tx_line;
  } res_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/u8n1_front.sv
// Front end: takes stream items, decodes the item kind and holds them
// in one register until the queue has room. Depends on u8n1_pkg.
`timescale 1ns / 1ps

module u8n1_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [u8n1_pkg::IN_DATA_W-1:0]  in_tdata,  // [7:0] send_byte, [8] rx_line, rest zero
  input  logic [u8n1_pkg::IN_USER_W-1:0]  in_tuser,  // [0] op
  input  u8n1_pkg::q_stat_t               q_stat,
  output logic                            push,
  output u8n1_pkg::item_t                 push_item
);

  logic             hold_valid_r, hold_valid_nxt;
  u8n1_pkg::item_t  hold_item_r, hold_item_nxt;
  u8n1_pkg::item_t  dec_item;
  logic             take;

  // Decode the incoming item
  always_comb begin
    dec_item.kind      = in_tuser[0] ? u8n1_pkg::OP_SEND : u8n1_pkg::OP_TICK;
    dec_item.send_byte = in_tdata[u8n1_pkg::BYTE_W-1:0];
    dec_item.rx_line   = in_tdata[u8n1_pkg::BYTE_W];
  end

  assign push      = hold_valid_r && !q_stat.full;
  assign push_item = hold_item_r;
  assign in_tready = !hold_valid_r || !q_stat.full;
  assign take      = in_tvalid && in_tready;

  // Holding register
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_item_nxt  = hold_item_r;
    if (take) begin
      hold_valid_nxt = 1'b1;
      hold_item_nxt  = dec_item;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_item_r <= hold_item_nxt;
  end

endmodule

// File: rtl/core/u8n1_queue.sv
// Short item queue between front and back ends.
// Depends on u8n1_pkg.
`timescale 1ns / 1ps

module u8n1_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8n1_pkg::item_t   push_item,
  input  logic              pop,
  output u8n1_pkg::item_t   pop_item,
  output u8n1_pkg::q_stat_t q_stat
);

  u8n1_pkg::item_t                slot_r [u8n1_pkg::QUEUE_DEPTH];
  logic [u8n1_pkg::QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [u8n1_pkg::QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [u8n1_pkg::QUEUE_AW:0]    count_r, count_nxt;
  logic                           do_push, do_pop;

  assign q_stat.full  = (count_r == (u8n1_pkg::QUEUE_AW + 1)'(u8n1_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_item     = slot_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/u8n1_back.sv
// Back end: transmit and receive engines advanced by one tick per item,
// half-bit count register and the result output register. Depends on u8n1_pkg.
`timescale 1ns / 1ps

module u8n1_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [u8n1_pkg::TIMER_W-1:0]      cfg_wr_data,
  input  u8n1_pkg::q_stat_t                 q_stat,
  input  u8n1_pkg::item_t                   pop_item,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output u8n1_pkg::res_t                    out_res
);

  localparam int PW = u8n1_pkg::PHASE_W;
  localparam int TW = u8n1_pkg::TIMER_W;
  localparam int DB = u8n1_pkg::DATA_BITS;
  localparam int BW = u8n1_pkg::BYTE_W;

  logic [TW-1:0]  half_bit_r;
  logic [TW-1:0]  reload;

  logic [TW-1:0]  tx_timer_r, tx_timer_nxt;
  logic [PW-1:0]  tx_phase_r, tx_phase_nxt;
  logic [BW-1:0]  tx_shift_r, tx_shift_nxt;
  logic           tx_level_r, tx_level_nxt;
  logic [TW-1:0]  rx_timer_r, rx_timer_nxt;
  logic [PW-1:0]  rx_phase_r, rx_phase_nxt;
  logic [DB-1:0]  rx_shift_r, rx_shift_nxt;

  logic           out_valid_r;
  u8n1_pkg::res_t out_res_r, res_nxt;

  logic           tx_done_nxt;
  logic           rx_valid_nxt, rx_error_nxt;
  logic [BW-1:0]  rx_byte_nxt;

  logic [PW-1:0]    tx_inc;
  logic [TW-1:0]    tx_dec, rx_dec;
  logic [PW-2:0]    rx_bit;
  logic             rx_keep;
  logic [DB+BW-1:0] rx_ext;

  // Half-bit count register, zero behaves as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_r <= u8n1_pkg::HALF_BIT_RST;
    end else if (cfg_wr_en) begin
      half_bit_r <= cfg_wr_data;
    end
  end
  assign reload = (half_bit_r == '0) ? TW'(1) : half_bit_r;

  // Step when an item waits and the output slot is free
  assign pop        = !q_stat.empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  // Transmitter
  always_comb begin
    tx_timer_nxt = tx_timer_r;
    tx_phase_nxt = tx_phase_r;
    tx_shift_nxt = tx_shift_r;
    tx_level_nxt = tx_level_r;
    tx_done_nxt  = 1'b0;
    tx_dec       = tx_timer_r - 1'b1;
    tx_inc       = tx_phase_r + 1'b1;
    if (tx_phase_r == '0) begin
      if (pop_item.kind == u8n1_pkg::OP_SEND) begin
        tx_shift_nxt = pop_item.send_byte;
        tx_level_nxt = 1'b0;
        tx_phase_nxt = PW'(1);
        tx_timer_nxt = reload;
      end
    end else begin
      tx_timer_nxt = tx_dec;
      if (tx_dec == '0) begin
        if (tx_inc > u8n1_pkg::TX_LAST_PHASE) begin
          tx_phase_nxt = '0;
          tx_level_nxt = 1'b1;
          tx_done_nxt  = 1'b1;
        end else begin
          tx_phase_nxt = tx_inc;
          tx_timer_nxt = reload;
          // odd half bit opens a new bit
          if (tx_inc[0]) begin
            if (tx_inc[PW-1:1] <= u8n1_pkg::DATA_IDX) begin
              tx_level_nxt = tx_shift_r[0];
              tx_shift_nxt = tx_shift_r >> 1;
            end else begin
              tx_level_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  // Receiver
  always_comb begin
    rx_timer_nxt = rx_timer_r;
    rx_phase_nxt = rx_phase_r;
    rx_shift_nxt = rx_shift_r;
    rx_valid_nxt = 1'b0;
    rx_error_nxt = 1'b0;
    rx_byte_nxt  = '0;
    rx_dec       = rx_timer_r - 1'b1;
    rx_bit       = rx_phase_r[PW-1:1];
    rx_keep      = 1'b1;
    rx_ext       = {{BW{1'b0}}, rx_shift_r};
    if (rx_phase_r == '0) begin
      if (!pop_item.rx_line) begin
        rx_phase_nxt = PW'(1);
        rx_shift_nxt = '0;
        rx_timer_nxt = reload;
      end
    end else begin
      rx_timer_nxt = rx_dec;
      if (rx_dec == '0) begin
        // mid-bit sample on odd half bits
        if (rx_phase_r[0]) begin
          if (rx_bit == '0) begin
            if (pop_item.rx_line) begin
              rx_error_nxt = 1'b1;
              rx_keep      = 1'b0;
            end
          end else if (rx_bit <= u8n1_pkg::DATA_IDX) begin
            rx_shift_nxt = {pop_item.rx_line, rx_shift_r[DB-1:1]};
          end else begin
            if (pop_item.rx_line) begin
              rx_valid_nxt = 1'b1;
              rx_byte_nxt  = rx_ext[BW-1:0];
            end else begin
              rx_error_nxt = 1'b1;
            end
            rx_keep = 1'b0;
          end
        end
        if (rx_keep) begin
          rx_phase_nxt = rx_phase_r + 1'b1;
          rx_timer_nxt = reload;
        end else begin
          rx_phase_nxt = '0;
        end
      end
    end
  end

  // Result fields for this tick
  always_comb begin
    res_nxt.tx_line  = tx_level_nxt;
    res_nxt.tx_busy  = (tx_phase_nxt != '0);
    res_nxt.tx_done  = tx_done_nxt;
    res_nxt.rx_valid = rx_valid_nxt;
    res_nxt.rx_byte  = rx_byte_nxt;
    res_nxt.rx_error = rx_error_nxt;
  end

  // Engine state advances once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_timer_r <= '0;
      tx_phase_r <= '0;
      tx_shift_r <= '0;
      tx_level_r <= 1'b1;
      rx_timer_r <= '0;
      rx_phase_r <= '0;
      rx_shift_r <= '0;
    end else if (pop) begin
      tx_timer_r <= tx_timer_nxt;
      tx_phase_r <= tx_phase_nxt;
      tx_shift_r <= tx_shift_nxt;
      tx_level_r <= tx_level_nxt;
      rx_timer_r <= rx_timer_nxt;
      rx_phase_r <= rx_phase_nxt;
      rx_shift_r <= rx_shift_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (pop) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

// File: rtl/core/uart_8n1_transceiver_unit.sv
// Top level of the 8N1 serial transceiver: front end, item queue, back end.
// Depends on u8n1_pkg, u8n1_front, u8n1_queue and u8n1_back.
//
// Usage:
//  - Each input item is one tick of the serial timebase. in_tuser[0] asks
//    to send the byte in in_tdata[7:0]; in_tdata[8] is the sampled rx pin.
//  - Each item yields exactly one result item on the out_ channel with the
//    transmit pin level, busy and done flags and the receive byte/status.
//  - cfg_wr_en/cfg_wr_data load the half-bit tick count (reset value 31,
//    zero acts as one); write only while no item is in flight.
//  - Throughput is one item per cycle while the output is not stalled. An
//    accepted item sits in the front holding register, moves to the queue
//    and then to the back-end output register, where its result is valid.
//  - The queue holds four items, so after the output stalls the input side
//    accepts until queue and holding register fill; then in_tready drops.
//  - Reset is synchronous and active low: transmitter idle with the line
//    high, receiver waiting for a start bit, queue empty, no result valid.
`timescale 1ns / 1ps

module uart_8n1_transceiver_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [u8n1_pkg::TIMER_W-1:0]     cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [u8n1_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] send_byte, [8] rx_line
  input  logic [u8n1_pkg::IN_USER_W-1:0]   in_tuser,   // [0] op
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] tx_line, [1] tx_busy, [2] tx_done, [3] rx_valid, [11:4] rx_byte, [12] rx_error
  output logic [u8n1_pkg::OUT_DATA_W-1:0]  out_tdata
);

  u8n1_pkg::q_stat_t q_stat;
  u8n1_pkg::item_t   push_item, pop_item;
  u8n1_pkg::res_t    out_res;
  logic              push, pop;

  u8n1_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  u8n1_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  u8n1_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .pop_item    (pop_item),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_res     (out_res)
  );

  assign out_tdata = {(u8n1_pkg::OUT_DATA_W - $bits(u8n1_pkg::res_t))'(0), out_res};

  // Frame end leaves the transmitter idle with the line high
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.tx_done |-> !out_res.tx_busy && out_res.tx_line)
    else $error("tx_done with transmitter still busy or line low");

  // Good byte and framing error never coincide
  a_rx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_res.rx_valid && out_res.rx_error))
    else $error("rx_valid and rx_error together");

  // Byte field is zero unless a byte is reported
  a_rx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_res.rx_valid |-> out_res.rx_byte == '0)
    else $error("rx_byte set without rx_valid");

  // Queue never pops and reports empty at once
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("back end stepped with no queued item");

endmodule

// File: test/testbench.sv
// Self-checking bench for the 8N1 serial transceiver: random and directed ticks.
// Predicts every result with its own transmitter/receiver model and checks each one.
// Depends on u8n1_pkg and uart_8n1_transceiver_unit.
`timescale 1ns / 1ps

module testbench;

  localparam int DATA_BITS    = u8n1_pkg::DATA_BITS;
  localparam int TIMER_W      = u8n1_pkg::TIMER_W;
  localparam int BYTE_W       = u8n1_pkg::BYTE_W;
  localparam int IN_DATA_W    = u8n1_pkg::IN_DATA_W;
  localparam int IN_USER_W    = u8n1_pkg::IN_USER_W;
  localparam int OUT_DATA_W   = u8n1_pkg::OUT_DATA_W;
  localparam int FRAME_HALVES = 2 * (DATA_BITS + 2);
  localparam int RES_W        = $bits(u8n1_pkg::res_t);
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [TIMER_W-1:0]    cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [7:0] send_byte, [8] rx_line
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [0] op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] tx_line, [1] tx_busy, [2] tx_done, [3] rx_valid, [11:4] rx_byte, [12] rx_error
  logic [OUT_DATA_W-1:0] out_tdata;

  uart_8n1_transceiver_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Serial link state as the predictor sees it
  logic [TIMER_W-1:0] half_ticks = u8n1_pkg::HALF_BIT_RST;
  logic [TIMER_W-1:0] tx_tmr = '0;
  logic [4:0]         tx_ph = '0;
  logic [BYTE_W-1:0]  tx_sh = '0;
  logic               tx_lvl = 1'b1;
  logic [TIMER_W-1:0] rx_tmr = '0;
  logic [4:0]         rx_ph = '0;
  logic [BYTE_W-1:0]  rx_sh = '0;

  u8n1_pkg::item_t  tick_q[$];          // ticks waiting to be driven
  u8n1_pkg::res_t   awaited_results[$]; // predicted link outputs, oldest first
  logic             rx_wave[$];         // receive pin levels still to be turned into ticks
  u8n1_pkg::item_t  cur;
  u8n1_pkg::res_t   want;
  u8n1_pkg::res_t   seen;
  int     pushed_cnt = 0;
  int     taken_cnt = 0;
  int     fault_cnt = 0;
  int     cycle_cnt = 0;
  int     burst_left = 1;
  int     gap_left = 0;
  int     ready_left = 0;
  int     stall_left = 0;
  logic   in_took = 1'b0;
  logic   steady = 1'b0;

  // One tick of the transmitter and receiver; r gets this tick's outputs
  task automatic advance_serial_link(input u8n1_pkg::op_e_t kind,
                                     input logic [BYTE_W-1:0] sb,
                                     input logic line, output u8n1_pkg::res_t r);
    logic [TIMER_W-1:0] rl;
    int bit_idx;
    r = '0;
    rl = (half_ticks == '0) ? TIMER_W'(1) : half_ticks;
    // transmitter
    if (tx_ph == '0) begin
      if (kind == u8n1_pkg::OP_SEND) begin
        tx_sh = sb;
        tx_lvl = 1'b0;
        tx_ph = 5'd1;
        tx_tmr = rl;
      end
    end else begin
      tx_tmr = tx_tmr - 1'b1;
      if (tx_tmr == '0) begin
        tx_ph = tx_ph + 1'b1;
        if (int'(tx_ph) > FRAME_HALVES) begin
          tx_ph = '0;
          tx_lvl = 1'b1;
          r.tx_done = 1'b1;
        end else begin
          tx_tmr = rl;
          if (tx_ph[0]) begin
            bit_idx = (int'(tx_ph) - 1) / 2;
            if (bit_idx <= DATA_BITS) begin
              tx_lvl = tx_sh[0];
              tx_sh = tx_sh >> 1;
            end else begin
              tx_lvl = 1'b1;
            end
          end
        end
      end
    end
    // receiver: samples at mid-bit on odd half bits
    if (rx_ph == '0) begin
      if (!line) begin
        rx_ph = 5'd1;
        rx_sh = '0;
        rx_tmr = rl;
      end
    end else begin
      rx_tmr = rx_tmr - 1'b1;
      if (rx_tmr == '0) begin
        if (rx_ph[0]) begin
          bit_idx = (int'(rx_ph) - 1) / 2;
          if (bit_idx == 0) begin
            if (line) begin
              r.rx_error = 1'b1;
              rx_ph = '0;
            end
          end else if (bit_idx <= DATA_BITS) begin
            rx_sh = {line, rx_sh[BYTE_W-1:1]};
          end else begin
            if (line) begin
              r.rx_valid = 1'b1;
              r.rx_byte = rx_sh;
            end else begin
              r.rx_error = 1'b1;
            end
            rx_ph = '0;
          end
        end
        if (rx_ph != '0) begin
          rx_ph = rx_ph + 1'b1;
          rx_tmr = rl;
        end
      end
    end
    r.tx_line = tx_lvl;
    r.tx_busy = (tx_ph != '0);
  endtask

  task automatic log_fault(input string what, input u8n1_pkg::res_t exp_r,
                           input logic [OUT_DATA_W-1:0] got);
    u8n1_pkg::res_t g;
    g = got[RES_W-1:0];
    fault_cnt++;
    if (fault_cnt <= MAX_REPORTS) begin
      $display("mismatch %s: exp line=%0b busy=%0b done=%0b valid=%0b byte=%02h err=%0b",
               what, exp_r.tx_line, exp_r.tx_busy, exp_r.tx_done, exp_r.rx_valid,
               exp_r.rx_byte, exp_r.rx_error);
      $display("  got line=%0b busy=%0b done=%0b valid=%0b byte=%02h err=%0b pad=%0h",
               g.tx_line, g.tx_busy, g.tx_done, g.rx_valid, g.rx_byte, g.rx_error,
               got[OUT_DATA_W-1:RES_W]);
    end
  endtask

  // Monitor: check results, then predict for the item taken this edge
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        log_fault("no item awaited", '0, out_tdata);
      end else begin
        want = awaited_results.pop_front();
        seen = out_tdata[RES_W-1:0];
        if (out_tdata[OUT_DATA_W-1:RES_W] != '0 || seen.tx_line != want.tx_line ||
            seen.tx_busy != want.tx_busy || seen.tx_done != want.tx_done ||
            seen.rx_valid != want.rx_valid || seen.rx_byte != want.rx_byte ||
            seen.rx_error != want.rx_error)
          log_fault("field", want, out_tdata);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      advance_serial_link(u8n1_pkg::op_e_t'(in_tuser[0]), in_tdata[7:0], in_tdata[8], want);
      awaited_results.push_back(want);
      taken_cnt <= taken_cnt + 1;
    end
  end

  // Driver: ticks go out in bursts; the result side stalls on its own pattern; steady turns both off
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_took) begin
        if (gap_left != 0 && !steady) begin
          in_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (tick_q.size() != 0) begin
          cur = tick_q.pop_front();
          in_tdata <= {{(IN_DATA_W - BYTE_W - 1){1'b0}}, cur.rx_line, cur.send_byte};
          in_tuser <= cur.kind;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (steady) begin
        out_tready <= 1'b1;
      end else if (ready_left != 0) begin
        out_tready <= 1'b1;
        ready_left <= ready_left - 1;
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_tready <= 1'b0;
        ready_left <= $urandom_range(0, 24);
        stall_left <= $urandom_range(1, 5);
      end
    end
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    logic [BYTE_W-1:0] v;
    v = BYTE_W'($urandom);
    case ($urandom_range(0, 7))
      0: v = 8'h00;
      1: v = 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_tick(input u8n1_pkg::op_e_t kind, input logic [BYTE_W-1:0] sb,
                           input logic line);
    u8n1_pkg::item_t it;
    it.kind = kind;
    it.send_byte = sb;
    it.rx_line = line;
    tick_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic wait_drained();
    while (taken_cnt != pushed_cnt || awaited_results.size() != 0) @(posedge clk);
  endtask

  // Register write once the pipeline is empty and settled
  task automatic write_half_ticks(input logic [TIMER_W-1:0] v);
    wait_drained();
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    half_ticks = v;
  endtask

  task automatic wave_level(input logic lvl, input int n);
    repeat (n) rx_wave.push_back(lvl);
  endtask

  // Start bit, data LSB first, stop bit; each bit two half bits long
  task automatic wave_frame(input int hb, input logic [BYTE_W-1:0] data, input logic stop_lvl);
    wave_level(1'b0, 2 * hb);
    for (int i = 0; i < DATA_BITS; i++) wave_level(data[i], 2 * hb);
    wave_level(stop_lvl, 2 * hb);
  endtask

  // Turn the pending pin levels into ticks; 1 in send_odds carries a send request
  task automatic emit_wave(input int send_odds);
    logic lvl;
    u8n1_pkg::op_e_t kind;
    while (rx_wave.size() != 0) begin
      lvl = rx_wave.pop_front();
      kind = (send_odds != 0 && $urandom_range(1, send_odds) == 1) ?
             u8n1_pkg::OP_SEND : u8n1_pkg::OP_TICK;
      push_tick(kind, rand_byte(), lvl);
    end
  endtask

  // Mostly clean frames, some with a low stop bit, false starts and line noise
  task automatic random_phase(input logic [TIMER_W-1:0] hreg, input int n_ticks);
    int hb;
    int pick;
    int n;
    hb = (hreg == '0) ? 1 : int'(hreg);
    write_half_ticks(hreg);
    while (rx_wave.size() < n_ticks) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        wave_frame(hb, rand_byte(), 1'b1);
      end else if (pick == 7) begin
        wave_frame(hb, rand_byte(), 1'b0);
      end else if (pick == 8) begin
        wave_level(1'b0, $urandom_range(1, hb));
        wave_level(1'b1, 2 * hb);
      end else begin
        n = $urandom_range(1, 4 * hb);
        repeat (n) rx_wave.push_back(1'($urandom_range(0, 1)));
      end
      wave_level(1'b1, $urandom_range(0, 2 * hb));
    end
    emit_wave(4);
  endtask

  initial begin
    logic lvl;
    int i;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset count of 31: start a send and a receive, pass the start-bit check,
    // then drop the count to one mid-frame and let both frames finish
    push_tick(u8n1_pkg::OP_SEND, 8'h3C, 1'b1);
    wave_level(1'b0, 40);
    wave_level(1'b1, 30);
    emit_wave(0);
    write_half_ticks(16'd1);
    wave_level(1'b1, 50);
    emit_wave(0);

    // directed at one tick per half bit: all-zero byte in, all-ones byte out,
    // a request while busy, then a false start
    wave_frame(1, 8'h00, 1'b1);
    i = 0;
    while (rx_wave.size() != 0) begin
      lvl = rx_wave.pop_front();
      if (i == 0) push_tick(u8n1_pkg::OP_SEND, 8'hFF, lvl);
      else if (i == 5) push_tick(u8n1_pkg::OP_SEND, 8'h00, lvl);
      else push_tick(u8n1_pkg::OP_TICK, 8'h00, lvl);
      i++;
    end
    push_tick(u8n1_pkg::OP_TICK, 8'h55, 1'b0);
    push_tick(u8n1_pkg::OP_TICK, 8'hAA, 1'b1);
    push_tick(u8n1_pkg::OP_TICK, 8'h00, 1'b1);

    // random traffic over short half-bit counts, zero acting as one
    random_phase(16'd0, 35);
    random_phase(16'd2, 35);
    random_phase(16'd1, 35);
    random_phase(16'd3, 35);
    random_phase(16'd2, 35);
    random_phase(16'd1, 35);

    // largest count: start both paths and check that neither timer runs out early
    write_half_ticks(16'hFFFF);
    steady = 1'b1;
    push_tick(u8n1_pkg::OP_SEND, 8'hA5, 1'b0);
    repeat (20) push_tick(u8n1_pkg::op_e_t'(1'($urandom_range(0, 1))), rand_byte(), 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fault_cnt == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
